// File: rtl/lra_pkg.sv
// Shared types and constants for the clipped line rasterizer.
// Used by the step unit and the top level.
package lra_pkg;

   // Default build values
   localparam int MAX_CANVAS_DEF = 64;
   localparam int COORD_BITS_DEF = 8;

   // Pixel coordinate width on the result channel
   localparam int PIX_BITS = 6;

   // Canvas size registers
   localparam int CFG_BITS  = 7;
   localparam int CFG_RESET = 64;
   localparam int ADDR_BITS = 3;
   localparam int DATA_BITS = 32;

   // Register indexes, decoded from the word address
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_WALK,
      ST_FLUSH
   } state_type;

   // Status of the current walk point, from the step unit
   typedef struct packed {
      logic in_canvas;
      logic at_end;
   } step_status_type;

endpackage

// File: rtl/lra_channels_if.sv
// Valid/ready channel interfaces for line commands and pixel writes.
// Depends on nothing; widths come from the top level's parameters.
interface lra_req_if #(
   parameter int COORD_BITS = 8
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [7:0]                   ink;

   modport source (output valid, start_x, start_y, end_x, end_y, ink, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, ink, output ready);
endinterface

interface lra_rsp_if #(
   parameter int PIX_BITS = 6
);
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] pixel_x;
   logic [PIX_BITS-1:0] pixel_y;
   logic [7:0]          pixel_ink;
   logic                last_point;

   modport source (output valid, pixel_x, pixel_y, pixel_ink, last_point, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_ink, last_point, output ready);
endinterface

// File: rtl/line_rasterizer_clipped_top.sv
// Clipped Bresenham line rasterizer, top level with canvas size registers.
// Sequence: accept in idle, a setup state, then one line point per cycle while the
// result port is not stalled (max(|dx|,|dy|)+1 points, at most 2^COORD_BITS) and a
// flush state; a stalled result port holds the walk. The step unit sets the
// one-point-per-cycle rate; a new command is taken only once the previous one is flushed.
// Reset (synchronous, active high) idles the sequencer and sets both sizes to 64.
module line_rasterizer_clipped_top #(
   parameter int MAX_CANVAS = lra_pkg::MAX_CANVAS_DEF,
   parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   lra_req_if.sink                           req,
   lra_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [lra_pkg::ADDR_BITS-1:0]     paddr,
   input  logic [lra_pkg::DATA_BITS-1:0]     pwdata,
   output logic [lra_pkg::DATA_BITS-1:0]     prdata,
   output logic                              pready
);
   localparam int PIX_BITS = lra_pkg::PIX_BITS;
   localparam int ERR_W    = COORD_BITS + 2;
   localparam int CB       = lra_pkg::CFG_BITS;
   localparam logic [CB-1:0] MAX_C = CB'(MAX_CANVAS);

   // Canvas size registers
   logic [CB-1:0] width_ff, height_ff;
   logic [CB-1:0] lim_w, lim_h;

   // Sequencer and walk registers
   lra_pkg::state_type           state_ff, state_in;
   logic signed [COORD_BITS-1:0] walk_x_ff, walk_x_in, walk_y_ff, walk_y_in;
   logic signed [COORD_BITS-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic signed [ERR_W-1:0]      err_ff, err_in;
   logic [COORD_BITS-1:0]        span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic [1:0]                   signs_ff, signs_in;
   logic [7:0]                   ink_ff, ink_in;
   logic                         held_valid_ff, held_valid_in;
   logic [PIX_BITS-1:0]          held_x_ff, held_x_in, held_y_ff, held_y_in;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIX_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [7:0]          rsp_ink_ff, rsp_ink_in;
   logic                rsp_last_ff, rsp_last_in;

   // Step unit results
   logic signed [COORD_BITS-1:0] next_x, next_y;
   logic signed [ERR_W-1:0]      next_err;
   lra_pkg::step_status_type     status;

   // Setup arithmetic
   logic [COORD_BITS:0] dx_s, dy_s, dx_a, dy_a;
   logic                out_free;
   logic                push;
   logic                cfg_write;

   // Register write on the access phase
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CB'(lra_pkg::CFG_RESET);
         height_ff <= CB'(lra_pkg::CFG_RESET);
      end else if (cfg_write) begin
         unique case (paddr[2])
            lra_pkg::REG_WIDTH:  width_ff  <= pwdata[CB-1:0];
            lra_pkg::REG_HEIGHT: height_ff <= pwdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // Read back the addressed register
   always_comb begin
      unique case (paddr[2])
         lra_pkg::REG_WIDTH:  prdata = lra_pkg::DATA_BITS'(width_ff);
         lra_pkg::REG_HEIGHT: prdata = lra_pkg::DATA_BITS'(height_ff);
         default:             prdata = '0;
      endcase
   end

   // Saturate the canvas at its largest size
   assign lim_w = (width_ff > MAX_C) ? MAX_C : width_ff;
   assign lim_h = (height_ff > MAX_C) ? MAX_C : height_ff;

   lra_step #(
      .COORD_BITS (COORD_BITS)
   ) u_step (
      .walk_x   (walk_x_ff),
      .walk_y   (walk_y_ff),
      .end_x    (end_x_ff),
      .end_y    (end_y_ff),
      .err      (err_ff),
      .span_x   (span_x_ff),
      .span_y   (span_y_ff),
      .signs    (signs_ff),
      .lim_w    (lim_w),
      .lim_h    (lim_h),
      .next_x   (next_x),
      .next_y   (next_y),
      .next_err (next_err),
      .status   (status)
   );

   // Spans and step directions from the latched end points
   always_comb begin
      dx_s = {end_x_ff[COORD_BITS-1], end_x_ff} - {walk_x_ff[COORD_BITS-1], walk_x_ff};
      dy_s = {end_y_ff[COORD_BITS-1], end_y_ff} - {walk_y_ff[COORD_BITS-1], walk_y_ff};
      dx_a = dx_s[COORD_BITS] ? -dx_s : dx_s;
      dy_a = dy_s[COORD_BITS] ? -dy_s : dy_s;
   end

   assign req.ready = (state_ff == lra_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // Next state, walk update and pixel transfer
   always_comb begin
      state_in      = state_ff;
      walk_x_in     = walk_x_ff;
      walk_y_in     = walk_y_ff;
      end_x_in      = end_x_ff;
      end_y_in      = end_y_ff;
      err_in        = err_ff;
      span_x_in     = span_x_ff;
      span_y_in     = span_y_ff;
      signs_in      = signs_ff;
      ink_in        = ink_ff;
      held_valid_in = held_valid_ff;
      held_x_in     = held_x_ff;
      held_y_in     = held_y_ff;
      push          = 1'b0;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_ink_in    = rsp_ink_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         lra_pkg::ST_IDLE: begin
            if (req.valid) begin
               walk_x_in     = req.start_x;
               walk_y_in     = req.start_y;
               end_x_in      = req.end_x;
               end_y_in      = req.end_y;
               ink_in        = req.ink;
               held_valid_in = 1'b0;
               state_in      = lra_pkg::ST_SETUP;
            end
         end
         lra_pkg::ST_SETUP: begin
            span_x_in = dx_a[COORD_BITS-1:0];
            span_y_in = dy_a[COORD_BITS-1:0];
            signs_in  = {dy_s[COORD_BITS] || (dy_s == '0),
                         dx_s[COORD_BITS] || (dx_s == '0)};
            err_in    = ERR_W'(dx_a[COORD_BITS-1:0]) - ERR_W'(dy_a[COORD_BITS-1:0]);
            state_in  = lra_pkg::ST_WALK;
         end
         lra_pkg::ST_WALK: begin
            if (out_free) begin
               if (status.in_canvas) begin
                  push          = held_valid_ff;
                  rsp_last_in   = 1'b0;
                  held_valid_in = 1'b1;
                  held_x_in     = walk_x_ff[PIX_BITS-1:0];
                  held_y_in     = walk_y_ff[PIX_BITS-1:0];
               end
               if (status.at_end) begin
                  state_in = lra_pkg::ST_FLUSH;
               end else begin
                  walk_x_in = next_x;
                  walk_y_in = next_y;
                  err_in    = next_err;
               end
            end
         end
         lra_pkg::ST_FLUSH: begin
            if (out_free) begin
               push          = held_valid_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = lra_pkg::ST_IDLE;
            end
         end
         default: state_in = lra_pkg::ST_IDLE;
      endcase

      // Load the output register with the held point
      if (push) begin
         rsp_x_in   = held_x_ff;
         rsp_y_in   = held_y_ff;
         rsp_ink_in = ink_ff;
      end
      rsp_valid_in = push ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lra_pkg::ST_IDLE;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      walk_x_ff   <= walk_x_in;
      walk_y_ff   <= walk_y_in;
      end_x_ff    <= end_x_in;
      end_y_ff    <= end_y_in;
      err_ff      <= err_in;
      span_x_ff   <= span_x_in;
      span_y_ff   <= span_y_in;
      signs_ff    <= signs_in;
      ink_ff      <= ink_in;
      held_x_ff   <= held_x_in;
      held_y_ff   <= held_y_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_ink_ff  <= rsp_ink_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.pixel_x    = rsp_x_ff;
   assign rsp.pixel_y    = rsp_y_ff;
   assign rsp.pixel_ink  = rsp_ink_ff;
   assign rsp.last_point = rsp_last_ff;

   // No point stays held between lines
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lra_pkg::ST_IDLE) |-> !held_valid_ff)
      else $error("held point left over in idle");

   // An accepted command always goes to setup
   a_accept_setup: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff == lra_pkg::ST_SETUP))
      else $error("accepted command did not enter setup");

   // A flush that completes marks its transfer as the last point
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lra_pkg::ST_FLUSH && out_free && held_valid_ff)
      |=> (rsp_valid_ff && rsp_last_ff && state_ff == lra_pkg::ST_IDLE))
      else $error("flush did not present a last point");

   // A walk point is never pushed while the output register is stalled
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp.ready) |=> ($stable(rsp_x_ff) && $stable(rsp_y_ff)))
      else $error("stalled pixel was overwritten");

endmodule

// File: rtl/lra_step.sv
// Bresenham step unit: error-term update, point advance and canvas test.
// Depends on lra_pkg for the status struct and register width.
module lra_step #(
   parameter int COORD_BITS = lra_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0]   walk_x,
   input  logic signed [COORD_BITS-1:0]   walk_y,
   input  logic signed [COORD_BITS-1:0]   end_x,
   input  logic signed [COORD_BITS-1:0]   end_y,
   input  logic signed [COORD_BITS+1:0]   err,
   input  logic [COORD_BITS-1:0]          span_x,
   input  logic [COORD_BITS-1:0]          span_y,
   input  logic [1:0]                     signs,
   input  logic [lra_pkg::CFG_BITS-1:0]   lim_w,
   input  logic [lra_pkg::CFG_BITS-1:0]   lim_h,
   output logic signed [COORD_BITS-1:0]   next_x,
   output logic signed [COORD_BITS-1:0]   next_y,
   output logic signed [COORD_BITS+1:0]   next_err,
   output lra_pkg::step_status_type       status
);
   localparam int ERR_W = COORD_BITS + 2;
   localparam int E2_W  = COORD_BITS + 3;
   localparam int CMP_W = (COORD_BITS > lra_pkg::CFG_BITS ?
                           COORD_BITS : lra_pkg::CFG_BITS) + 1;

   logic signed [ERR_W-1:0] dx_e;
   logic signed [ERR_W-1:0] dy_e;
   logic signed [E2_W-1:0]  e2;
   logic signed [E2_W-1:0]  dx_w;
   logic signed [E2_W-1:0]  ndy_w;
   logic                    step_x;
   logic                    step_y;

   // Compare doubled error against the spans
   always_comb begin
      dx_e   = $signed({2'b00, span_x});
      dy_e   = $signed({2'b00, span_y});
      e2     = $signed({err, 1'b0});
      dx_w   = $signed({3'b000, span_x});
      ndy_w  = -$signed({3'b000, span_y});
      step_x = e2 > ndy_w;
      step_y = e2 < dx_w;
   end

   // Advance the point and the error term
   always_comb begin
      next_err = err - (step_x ? dy_e : ERR_W'(0)) + (step_y ? dx_e : ERR_W'(0));
      next_x   = walk_x;
      next_y   = walk_y;
      if (step_x) begin
         next_x = walk_x + (signs[0] ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
      end
      if (step_y) begin
         next_y = walk_y + (signs[1] ? {COORD_BITS{1'b1}} : COORD_BITS'(1));
      end
   end

   // Test the current point against the canvas and the end point
   always_comb begin
      status.in_canvas = !walk_x[COORD_BITS-1] && !walk_y[COORD_BITS-1] &&
                         (CMP_W'($unsigned(walk_x)) < CMP_W'(lim_w)) &&
                         (CMP_W'($unsigned(walk_y)) < CMP_W'(lim_h));
      status.at_end    = (walk_x == end_x) && (walk_y == end_y);
   end

endmodule
